/* hdl/rcfsc_pkg.sv */
// Shared types and encodings for the RISC-V control-flow and stack predecoder.
// Used by rcfsc_decode, rcfsc_build and the top level in hdl/; depends on nothing.

package rcfsc_pkg;

  localparam int unsigned InWordW  = 32;
  localparam int unsigned AvailW   = 3;
  localparam int unsigned InDataW  = 40;  // 35 bits of fields, padded to bytes
  localparam int unsigned OutDataW = 72;  // 67 bits of fields, padded to bytes

  localparam logic [2:0] LenNone = 3'd0;
  localparam logic [2:0] LenComp = 3'd2;
  localparam logic [2:0] LenFull = 3'd4;

  localparam logic [4:0] RegZero = 5'd0;
  localparam logic [4:0] RegRa   = 5'd1;
  localparam logic [4:0] RegSp   = 5'd2;
  localparam logic [4:0] RegFp   = 5'd8;

  localparam logic [6:0] OpLoad   = 7'h03;
  localparam logic [6:0] OpStore  = 7'h23;
  localparam logic [6:0] OpImm    = 7'h13;
  localparam logic [6:0] OpJal    = 7'h6f;
  localparam logic [6:0] OpJalr   = 7'h67;
  localparam logic [6:0] OpBranch = 7'h63;
  localparam logic [6:0] OpSystem = 7'h73;

  // Compressed quadrant (bits 1:0); both bits set marks a full-length word.
  localparam logic [1:0] CQuad1    = 2'd1;
  localparam logic [1:0] CQuad2    = 2'd2;
  localparam logic [1:0] CQuadFull = 2'd3;

  // Compressed funct3 (bits 15:13).
  localparam logic [2:0] CFnAddi = 3'd0;
  localparam logic [2:0] CFnLui  = 3'd3;  // c.addi16sp when rd is sp
  localparam logic [2:0] CFnJr   = 3'd4;
  localparam logic [2:0] CFnJ    = 3'd5;
  localparam logic [2:0] CFnBeqz = 3'd6;
  localparam logic [2:0] CFnBnez = 3'd7;

  // Full-length funct3 (bits 14:12).
  localparam logic [2:0] FnZero  = 3'd0;  // addi, jalr, privileged
  localparam logic [2:0] FnDword = 3'd3;  // ld, sd

  localparam logic [31:0] WordNop  = 32'h0000_0013;
  localparam logic [11:0] F12Break = 12'h001;
  localparam logic [11:0] F12Sret  = 12'h102;
  localparam logic [11:0] F12Mret  = 12'h302;

  // Control-flow class codes as they appear on the result bus.
  typedef enum logic [3:0] {
    CLS_OTHER    = 4'd0,
    CLS_NOP      = 4'd1,
    CLS_RETURN   = 4'd2,
    CLS_JUMP_DYN = 4'd3,
    CLS_CALL     = 4'd4,
    CLS_CALL_DYN = 4'd5,
    CLS_JUMP     = 4'd6,
    CLS_COND     = 4'd7,
    CLS_BUG      = 4'd8
  } cls_t;

  // Immediate format to assemble in the last stage.
  typedef enum logic [3:0] {
    IMM_NONE,
    IMM_CI6,
    IMM_C16SP,
    IMM_CJ,
    IMM_CB,
    IMM_I,
    IMM_S,
    IMM_J,
    IMM_B
  } imm_sel_t;

  // Stack operation shape.
  typedef enum logic [2:0] {
    STK_NONE,
    STK_SP_SP,
    STK_LOAD,
    STK_STORE,
    STK_SP_FP,
    STK_FP_SP
  } stk_sel_t;

  localparam logic [1:0] SrcRegOff = 2'd0;
  localparam logic [1:0] SrcMem    = 2'd1;
  localparam logic [1:0] SrcReg    = 2'd2;
  localparam logic       DstReg    = 1'b0;
  localparam logic       DstMem    = 1'b1;

  typedef struct packed {
    cls_t     cls;
    imm_sel_t imm_sel;
    stk_sel_t stk_sel;
  } dec_t;

  typedef struct packed {
    logic               fp_restore_seen;
    logic signed [11:0] dest_offset;
    logic [4:0]         dest_reg;
    logic               dest_kind;
    logic signed [11:0] src_offset;
    logic [4:0]         src_reg;
    logic [1:0]         src_kind;
    logic               has_stack_op;
    logic signed [20:0] immediate;
    logic [3:0]         insn_class;
    logic [2:0]         insn_length;
  } res_t;

endpackage

/* hdl/rcfsc_decode.sv */
// Opcode decode: control-flow class, immediate format and stack operation shape.
// Depends on rcfsc_pkg.

module rcfsc_decode (
  input  logic [31:0]     word,
  input  logic [2:0]      len,
  output rcfsc_pkg::dec_t dec
);

  logic [1:0]  cq;
  logic [2:0]  cf3;
  logic [4:0]  cr1;
  logic [4:0]  cr2;
  logic        cb12;
  logic [6:0]  op;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [4:0]  rs1;
  logic [11:0] f12;

  assign cq   = word[1:0];
  assign cf3  = word[15:13];
  assign cr1  = word[11:7];
  assign cr2  = word[6:2];
  assign cb12 = word[12];
  assign op   = word[6:0];
  assign rd   = word[11:7];
  assign f3   = word[14:12];
  assign rs1  = word[19:15];
  assign f12  = word[31:20];

  always_comb begin
    dec.cls     = rcfsc_pkg::CLS_OTHER;
    dec.imm_sel = rcfsc_pkg::IMM_NONE;
    dec.stk_sel = rcfsc_pkg::STK_NONE;
    if (len == rcfsc_pkg::LenComp) begin
      if (word[15:0] == 16'h0000) begin
        dec.cls = rcfsc_pkg::CLS_NOP;
      end else if (cq == rcfsc_pkg::CQuad2 && cf3 == rcfsc_pkg::CFnJr) begin
        if (cr2 == rcfsc_pkg::RegZero) begin
          if (!cb12 && cr1 != rcfsc_pkg::RegZero) begin
            dec.cls = (cr1 == rcfsc_pkg::RegRa) ? rcfsc_pkg::CLS_RETURN
                                                : rcfsc_pkg::CLS_JUMP_DYN;
          end else if (cb12 && cr1 == rcfsc_pkg::RegZero) begin
            dec.cls = rcfsc_pkg::CLS_BUG;
          end
        end
      end else if (cq == rcfsc_pkg::CQuad1) begin
        case (cf3)
          rcfsc_pkg::CFnAddi: begin
            if (cr1 == rcfsc_pkg::RegZero) begin
              dec.cls = rcfsc_pkg::CLS_NOP;
            end else if (cr1 == rcfsc_pkg::RegSp) begin
              dec.imm_sel = rcfsc_pkg::IMM_CI6;
              dec.stk_sel = rcfsc_pkg::STK_SP_SP;
            end
          end
          rcfsc_pkg::CFnLui: begin
            if (cr1 == rcfsc_pkg::RegSp) begin
              dec.imm_sel = rcfsc_pkg::IMM_C16SP;
              dec.stk_sel = rcfsc_pkg::STK_SP_SP;
            end
          end
          rcfsc_pkg::CFnJ: begin
            dec.imm_sel = rcfsc_pkg::IMM_CJ;
            dec.cls     = rcfsc_pkg::CLS_JUMP;
          end
          rcfsc_pkg::CFnBeqz, rcfsc_pkg::CFnBnez: begin
            dec.imm_sel = rcfsc_pkg::IMM_CB;
            dec.cls     = rcfsc_pkg::CLS_COND;
          end
          default: begin
          end
        endcase
      end
    end else if (len == rcfsc_pkg::LenFull) begin
      case (op)
        rcfsc_pkg::OpLoad: begin
          if (f3 == rcfsc_pkg::FnDword &&
              (rs1 == rcfsc_pkg::RegSp || rs1 == rcfsc_pkg::RegFp)) begin
            dec.imm_sel = rcfsc_pkg::IMM_I;
            dec.stk_sel = rcfsc_pkg::STK_LOAD;
          end
        end
        rcfsc_pkg::OpStore: begin
          if (f3 == rcfsc_pkg::FnDword &&
              (rs1 == rcfsc_pkg::RegSp || rs1 == rcfsc_pkg::RegFp)) begin
            dec.imm_sel = rcfsc_pkg::IMM_S;
            dec.stk_sel = rcfsc_pkg::STK_STORE;
          end
        end
        rcfsc_pkg::OpImm: begin
          if (f3 == rcfsc_pkg::FnZero) begin
            if (rd == rcfsc_pkg::RegSp && rs1 == rcfsc_pkg::RegSp) begin
              dec.imm_sel = rcfsc_pkg::IMM_I;
              dec.stk_sel = rcfsc_pkg::STK_SP_SP;
            end else if (rd == rcfsc_pkg::RegFp && rs1 == rcfsc_pkg::RegSp) begin
              dec.imm_sel = rcfsc_pkg::IMM_I;
              dec.stk_sel = rcfsc_pkg::STK_SP_FP;
            end else if (rd == rcfsc_pkg::RegSp && rs1 == rcfsc_pkg::RegFp) begin
              dec.imm_sel = rcfsc_pkg::IMM_I;
              dec.stk_sel = rcfsc_pkg::STK_FP_SP;
            end else if (word == rcfsc_pkg::WordNop) begin
              dec.cls = rcfsc_pkg::CLS_NOP;
            end
          end
        end
        rcfsc_pkg::OpJal: begin
          dec.imm_sel = rcfsc_pkg::IMM_J;
          dec.cls     = (rd == rcfsc_pkg::RegZero) ? rcfsc_pkg::CLS_JUMP
                                                   : rcfsc_pkg::CLS_CALL;
        end
        rcfsc_pkg::OpJalr: begin
          if (f3 == rcfsc_pkg::FnZero) begin
            if (rd == rcfsc_pkg::RegZero && rs1 == rcfsc_pkg::RegRa && f12 == 12'h000) begin
              dec.cls = rcfsc_pkg::CLS_RETURN;
            end else if (rd == rcfsc_pkg::RegRa) begin
              dec.cls = rcfsc_pkg::CLS_CALL_DYN;
            end else begin
              dec.cls = rcfsc_pkg::CLS_JUMP_DYN;
            end
          end
        end
        rcfsc_pkg::OpBranch: begin
          dec.imm_sel = rcfsc_pkg::IMM_B;
          dec.cls     = rcfsc_pkg::CLS_COND;
        end
        rcfsc_pkg::OpSystem: begin
          if (f3 == rcfsc_pkg::FnZero) begin
            if (f12 == rcfsc_pkg::F12Break) begin
              dec.cls = rcfsc_pkg::CLS_BUG;
            end else if (f12 == rcfsc_pkg::F12Sret || f12 == rcfsc_pkg::F12Mret) begin
              dec.cls = rcfsc_pkg::CLS_RETURN;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* hdl/rcfsc_build.sv */
// Result assembly: immediate bit shuffle and stack operation fields.
// Depends on rcfsc_pkg.

module rcfsc_build (
  input  logic [31:0]     word,
  input  logic [2:0]      len,
  input  rcfsc_pkg::dec_t dec,
  output rcfsc_pkg::res_t res
);

  logic signed [20:0] imm;
  logic [11:0]        imm_lo;

  always_comb begin
    case (dec.imm_sel)
      rcfsc_pkg::IMM_CI6:
        imm = {{15{word[12]}}, word[12], word[6:2]};
      rcfsc_pkg::IMM_C16SP:
        imm = {{11{word[12]}}, word[12], word[4], word[3], word[5], word[2], word[6],
               4'b0000};
      rcfsc_pkg::IMM_CJ:
        imm = {{9{word[12]}}, word[12], word[8], word[10], word[9], word[6], word[7],
               word[2], word[11], word[5], word[4], word[3], 1'b0};
      rcfsc_pkg::IMM_CB:
        imm = {{12{word[12]}}, word[12], word[6], word[5], word[2], word[11], word[10],
               word[4], word[3], 1'b0};
      rcfsc_pkg::IMM_I:
        imm = {{9{word[31]}}, word[31:20]};
      rcfsc_pkg::IMM_S:
        imm = {{9{word[31]}}, word[31:25], word[11:7]};
      rcfsc_pkg::IMM_J:
        imm = {word[31], word[19:12], word[20], word[30:21], 1'b0};
      rcfsc_pkg::IMM_B:
        imm = {{8{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
      default:
        imm = '0;
    endcase
  end

  assign imm_lo = imm[11:0];

  always_comb begin
    res                 = '0;
    res.insn_length     = len;
    res.insn_class      = dec.cls;
    res.immediate       = imm;
    case (dec.stk_sel)
      rcfsc_pkg::STK_SP_SP: begin
        res.has_stack_op = 1'b1;
        res.src_kind     = rcfsc_pkg::SrcRegOff;
        res.src_reg      = rcfsc_pkg::RegSp;
        res.src_offset   = imm_lo;
        res.dest_kind    = rcfsc_pkg::DstReg;
        res.dest_reg     = rcfsc_pkg::RegSp;
      end
      rcfsc_pkg::STK_LOAD: begin
        res.has_stack_op = 1'b1;
        res.src_kind     = rcfsc_pkg::SrcMem;
        res.src_reg      = word[19:15];
        res.src_offset   = imm_lo;
        res.dest_kind    = rcfsc_pkg::DstReg;
        res.dest_reg     = word[11:7];
      end
      rcfsc_pkg::STK_STORE: begin
        res.has_stack_op = 1'b1;
        res.src_kind     = rcfsc_pkg::SrcReg;
        res.src_reg      = word[24:20];
        res.dest_kind    = rcfsc_pkg::DstMem;
        res.dest_reg     = word[19:15];
        res.dest_offset  = imm_lo;
      end
      rcfsc_pkg::STK_SP_FP: begin
        res.has_stack_op = 1'b1;
        res.src_kind     = rcfsc_pkg::SrcRegOff;
        res.src_reg      = rcfsc_pkg::RegSp;
        res.src_offset   = imm_lo;
        res.dest_kind    = rcfsc_pkg::DstReg;
        res.dest_reg     = rcfsc_pkg::RegFp;
      end
      rcfsc_pkg::STK_FP_SP: begin
        // sp restored from the frame pointer: flag it, do not tie to a frame
        res.fp_restore_seen = 1'b1;
        res.has_stack_op    = 1'b1;
        res.src_kind        = rcfsc_pkg::SrcRegOff;
        res.src_reg         = rcfsc_pkg::RegFp;
        res.src_offset      = imm_lo;
        res.dest_kind       = rcfsc_pkg::DstReg;
        res.dest_reg        = rcfsc_pkg::RegSp;
      end
      default: begin
      end
    endcase
  end

endmodule

/* hdl/riscv_control_flow_stack_classifier.sv */
// RISC-V predecoder top level: three-stage pipeline with stream ports.
// Depends on rcfsc_pkg, rcfsc_decode and rcfsc_build.

// Takes one instruction word per beat and returns one result beat for it, in order.
// Throughput is one word per clock while out_tready lets results leave; each word
// passes through the three register stages (length check, opcode decode,
// immediate and stack-field assembly). Each stage holds its beat only while the
// stage after it is full and stalled, so bubbles are squeezed out and input beats
// keep being taken while a finished result waits on out_tready, until all stages fill.

module riscv_control_flow_stack_classifier (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [31:0] instruction_word, [34:32] bytes_available, [39:35] zero
  input  logic [rcfsc_pkg::InDataW-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [2:0] insn_length, [6:3] insn_class, [27:7] immediate, [28] has_stack_op,
  // [30:29] src_kind, [35:31] src_reg, [47:36] src_offset, [48] dest_kind,
  // [53:49] dest_reg, [65:54] dest_offset, [66] fp_restore_seen, [71:67] zero
  output logic [rcfsc_pkg::OutDataW-1:0]   out_tdata
);

  logic [rcfsc_pkg::InWordW-1:0] in_word;
  logic [rcfsc_pkg::AvailW-1:0]  in_avail;
  logic [2:0]      len_nxt;

  logic            v1_r, v2_r, v3_r;
  logic            rdy1, rdy2, rdy3;
  logic [31:0]     word1_r, word2_r;
  logic [2:0]      len1_r, len2_r;
  rcfsc_pkg::dec_t dec_nxt, dec2_r;
  rcfsc_pkg::res_t res_nxt, res3_r;

  assign in_word  = in_tdata[rcfsc_pkg::InWordW-1:0];
  assign in_avail = in_tdata[rcfsc_pkg::InWordW +: rcfsc_pkg::AvailW];

  // A stage takes a new beat when it is empty or its beat moves on.
  assign rdy3      = !v3_r || out_tready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_comb begin
    if (in_avail >= 3'd2 && in_word[1:0] != rcfsc_pkg::CQuadFull) begin
      len_nxt = rcfsc_pkg::LenComp;
    end else if (in_avail >= 3'd4 && in_word[1:0] == rcfsc_pkg::CQuadFull) begin
      len_nxt = rcfsc_pkg::LenFull;
    end else begin
      len_nxt = rcfsc_pkg::LenNone;
    end
  end

  rcfsc_decode u_decode (
    .word (word1_r),
    .len  (len1_r),
    .dec  (dec_nxt)
  );

  rcfsc_build u_build (
    .word (word2_r),
    .len  (len2_r),
    .dec  (dec2_r),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_tvalid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) begin
      word1_r <= in_word;
      len1_r  <= len_nxt;
    end
    if (rdy2 && v1_r) begin
      word2_r <= word1_r;
      len2_r  <= len1_r;
      dec2_r  <= dec_nxt;
    end
    if (rdy3 && v2_r) begin
      res3_r <= res_nxt;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = {5'b00000, res3_r};

endmodule

/* hdl/rcfsc_checker.sv */
// Port-level assertions for the predecoder, bound to the top level.
// Depends on riscv_control_flow_stack_classifier port layout.

module rcfsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  logic [2:0] len;
  assign len = out_tdata[2:0];

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (len == 3'd0 || len == 3'd2 || len == 3'd4))
    else $error("illegal insn_length");

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && len == 3'd0 |-> out_tdata[66:3] == '0)
    else $error("undecoded beat carries nonzero fields");

  a_no_stack_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[28] |-> out_tdata[66:29] == '0)
    else $error("stack fields set without a stack operation");

  // A full pipe with a ready sink always takes the next beat.
  a_accept_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output drains");

endmodule

bind riscv_control_flow_stack_classifier rcfsc_checker u_rcfsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* test/predecode_monitor.sv */
// Instruction-field codes shared by the testbench files, and the monitor that predicts
// and checks every result beat of the RISC-V predecoder.
// Depends on rcfsc_pkg from hdl/.
`timescale 1ns / 1ps

package rv_enc_pkg;

  // Compressed quadrants (bits 1:0); a full-length word has both bits set.
  localparam logic [1:0] QuadC0   = 2'd0;
  localparam logic [1:0] QuadC1   = 2'd1;
  localparam logic [1:0] QuadC2   = 2'd2;

  // Compressed funct3 values (bits 15:13).
  localparam logic [2:0] CF3Addi  = 3'd0;
  localparam logic [2:0] CF3Lui   = 3'd3;  // c.addi16sp when rd is sp
  localparam logic [2:0] CF3Jr    = 3'd4;
  localparam logic [2:0] CF3J     = 3'd5;
  localparam logic [2:0] CF3Beqz  = 3'd6;
  localparam logic [2:0] CF3Bnez  = 3'd7;

  // Full-length funct3 values.
  localparam logic [2:0] F3Zero   = 3'd0;  // addi, jalr, beq, privileged
  localparam logic [2:0] F3Dword  = 3'd3;  // ld, sd

endpackage

module predecode_monitor
  import rcfsc_pkg::*;
  import rv_enc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  output int          mismatch_count,
  output int          results_owed
);

  res_t expected_results[$];

  function automatic res_t predecode(logic [31:0] w, logic [2:0] avail_raw);
    res_t r;
    logic [2:0] avail;
    logic [15:0] c;
    logic [4:0] r1, r2, rd, rs1, rs2;
    logic [2:0] f3;
    logic [20:0] iimm, simm;
    r = '0;
    avail = (avail_raw > 3'd4) ? 3'd4 : avail_raw;
    c = w[15:0];
    if (avail >= 3'd2 && w[1:0] != 2'b11) begin
      f3 = c[15:13];
      r1 = c[11:7];
      r2 = c[6:2];
      r.insn_length = LenComp;
      if (c == 16'h0000) begin
        r.insn_class = CLS_NOP;
      end else if (c[1:0] == QuadC2 && f3 == CF3Jr) begin
        if (r2 == RegZero) begin
          if (!c[12] && r1 != RegZero) begin
            r.insn_class = (r1 == RegRa) ? CLS_RETURN : CLS_JUMP_DYN;
          end else if (c[12] && r1 == RegZero) begin
            r.insn_class = CLS_BUG;
          end
        end
      end else if (c[1:0] == QuadC1) begin
        case (f3)
          CF3Addi: begin
            if (r1 == RegZero) begin
              r.insn_class = CLS_NOP;
            end else if (r1 == RegSp) begin
              r.immediate = {{15{c[12]}}, c[12], r2};
              r.has_stack_op = 1'b1;
              r.src_kind = SrcRegOff;
              r.src_reg = RegSp;
              r.src_offset = r.immediate[11:0];
              r.dest_kind = DstReg;
              r.dest_reg = RegSp;
            end
          end
          CF3Lui: begin
            if (r1 == RegSp) begin
              r.immediate = {{11{c[12]}}, c[12], c[4:3], c[5], c[2], c[6], 4'b0000};
              r.has_stack_op = 1'b1;
              r.src_kind = SrcRegOff;
              r.src_reg = RegSp;
              r.src_offset = r.immediate[11:0];
              r.dest_kind = DstReg;
              r.dest_reg = RegSp;
            end
          end
          CF3J: begin
            r.immediate = {{9{c[12]}}, c[12], c[8], c[10:9], c[6], c[7], c[2], c[11],
                           c[5:3], 1'b0};
            r.insn_class = CLS_JUMP;
          end
          CF3Beqz, CF3Bnez: begin
            r.immediate = {{12{c[12]}}, c[12], c[6:5], c[2], c[11:10], c[4:3], 1'b0};
            r.insn_class = CLS_COND;
          end
          default: ;
        endcase
      end
    end else if (avail == 3'd4) begin
      rd = w[11:7];
      f3 = w[14:12];
      rs1 = w[19:15];
      rs2 = w[24:20];
      iimm = {{9{w[31]}}, w[31:20]};
      simm = {{9{w[31]}}, w[31:25], w[11:7]};
      r.insn_length = LenFull;
      case (w[6:0])
        OpLoad: begin
          if (f3 == F3Dword && (rs1 == RegSp || rs1 == RegFp)) begin
            r.immediate = iimm;
            r.has_stack_op = 1'b1;
            r.src_kind = SrcMem;
            r.src_reg = rs1;
            r.src_offset = iimm[11:0];
            r.dest_kind = DstReg;
            r.dest_reg = rd;
          end
        end
        OpStore: begin
          if (f3 == F3Dword && (rs1 == RegSp || rs1 == RegFp)) begin
            r.immediate = simm;
            r.has_stack_op = 1'b1;
            r.src_kind = SrcReg;
            r.src_reg = rs2;
            r.dest_kind = DstMem;
            r.dest_reg = rs1;
            r.dest_offset = simm[11:0];
          end
        end
        OpImm: begin
          if (f3 == F3Zero) begin
            if ((rd == RegSp && (rs1 == RegSp || rs1 == RegFp)) ||
                (rd == RegFp && rs1 == RegSp)) begin
              // sp restored from s0 marks a frame-pointer function
              r.fp_restore_seen = (rs1 == RegFp);
              r.immediate = iimm;
              r.has_stack_op = 1'b1;
              r.src_kind = SrcRegOff;
              r.src_reg = rs1;
              r.src_offset = iimm[11:0];
              r.dest_kind = DstReg;
              r.dest_reg = rd;
            end else if (w == WordNop) begin
              r.insn_class = CLS_NOP;
            end
          end
        end
        OpJal: begin
          r.immediate = {w[31], w[19:12], w[20], w[30:21], 1'b0};
          r.insn_class = (rd == RegZero) ? CLS_JUMP : CLS_CALL;
        end
        OpJalr: begin
          if (f3 == F3Zero) begin
            if (rd == RegZero && rs1 == RegRa && w[31:20] == 12'h000) begin
              r.insn_class = CLS_RETURN;
            end else if (rd == RegRa) begin
              r.insn_class = CLS_CALL_DYN;
            end else begin
              r.insn_class = CLS_JUMP_DYN;
            end
          end
        end
        OpBranch: begin
          r.immediate = {{8{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
          r.insn_class = CLS_COND;
        end
        OpSystem: begin
          if (f3 == F3Zero) begin
            if (w[31:20] == F12Break) begin
              r.insn_class = CLS_BUG;
            end else if (w[31:20] == F12Sret || w[31:20] == F12Mret) begin
              r.insn_class = CLS_RETURN;
            end
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [20:0] want, logic [20:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    res_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(predecode(in_tdata[31:0], in_tdata[34:32]));
      end
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result beat 0x%0h with no instruction outstanding", out_tdata);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          got = out_tdata[66:0];
          check_field("insn_length", 21'(want.insn_length), 21'(got.insn_length));
          check_field("insn_class", 21'(want.insn_class), 21'(got.insn_class));
          check_field("immediate", want.immediate, got.immediate);
          check_field("has_stack_op", 21'(want.has_stack_op), 21'(got.has_stack_op));
          check_field("src_kind", 21'(want.src_kind), 21'(got.src_kind));
          check_field("src_reg", 21'(want.src_reg), 21'(got.src_reg));
          check_field("src_offset", 21'(want.src_offset), 21'(got.src_offset));
          check_field("dest_kind", 21'(want.dest_kind), 21'(got.dest_kind));
          check_field("dest_reg", 21'(want.dest_reg), 21'(got.dest_reg));
          check_field("dest_offset", 21'(want.dest_offset), 21'(got.dest_offset));
          check_field("fp_restore_seen", 21'(want.fp_restore_seen),
                      21'(got.fp_restore_seen));
          check_field("pad", 21'd0, 21'(out_tdata[71:67]));
        end
      end
      results_owed = expected_results.size();
    end
  end

endmodule

/* test/testbench.sv */
// Top of the predecoder testbench: clock, reset, instruction stimulus, result back-pressure
// and the verdict. Depends on rcfsc_pkg, rv_enc_pkg and predecode_monitor.
`timescale 1ns / 1ps

module testbench;
  import rcfsc_pkg::*;
  import rv_enc_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int RandomItems = 1200;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  int          mismatch_count;
  int          results_owed;

  int items_sent = 0;
  int burst_left = 0;
  bit rx_hold = 1'b0;
  bit long_hold_done = 1'b0;

  riscv_control_flow_stack_classifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  predecode_monitor predecode_mon (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .mismatch_count(mismatch_count),
    .results_owed  (results_owed)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OpStore};
  endfunction

  // Favor the registers that the stack and return decoding look at.
  function automatic logic [4:0] pick_reg();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return RegSp;
    if (r < 45) return RegFp;
    if (r < 60) return RegRa;
    if (r < 70) return RegZero;
    return 5'($urandom);
  endfunction

  function automatic logic [2:0] pick_avail();
    if ($urandom_range(0, 99) < 85) return 3'd4;
    return 3'($urandom_range(0, 7));
  endfunction

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    logic [6:0] op;
    int r;
    int sel;
    r = $urandom_range(0, 99);
    sel = $urandom_range(0, 99);
    w = $urandom;
    if (r < 2) begin
      w[15:0] = 16'h0000;
    end else if (r < 37) begin
      w[1:0] = (sel < 60) ? QuadC1 : (sel < 85) ? QuadC2 : QuadC0;
      if (w[1:0] == QuadC2 && $urandom_range(0, 1)) w[15:13] = CF3Jr;
      if ($urandom_range(0, 1)) w[11:7] = pick_reg();
      if ($urandom_range(0, 2) == 0) w[6:2] = RegZero;
    end else if (r < 88) begin
      case (sel % 7)
        0: op = OpLoad;
        1: op = OpStore;
        2: op = OpImm;
        3: op = OpJal;
        4: op = OpJalr;
        5: op = OpBranch;
        default: op = OpSystem;
      endcase
      w[6:0] = op;
      if ($urandom_range(0, 3) != 0) begin
        w[14:12] = (op == OpLoad || op == OpStore) ? F3Dword : F3Zero;
      end
      if ($urandom_range(0, 9) < 7) w[19:15] = pick_reg();
      if ($urandom_range(0, 9) < 6) w[11:7] = pick_reg();
      if (op == OpJalr && $urandom_range(0, 1)) w[31:20] = 12'h000;
      if (op == OpSystem && $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 3))
          0: w[31:20] = F12Break;
          1: w[31:20] = F12Sret;
          2: w[31:20] = F12Mret;
          default: w[31:20] = 12'h000;
        endcase
        if ($urandom_range(0, 1)) w[19:7] = '0;
      end
      if (op == OpImm && $urandom_range(0, 9) == 0) w = WordNop;
    end
    return w;
  endfunction

  function automatic int pick_gap();
    int r;
    if (rx_hold) return 0;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(30, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 97) return $urandom_range(1, 4);
    return $urandom_range(15, 50);
  endfunction

  task automatic send_insn(logic [31:0] word, logic [2:0] avail);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata <= {5'b0, 3'($urandom), 32'($urandom)};
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, avail, word};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  initial begin : stimulus
    in_tvalid = 1'b0;
    in_tdata = '0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_insn(32'h0000_0000, 3'd2);                      // all-zero halfword
    send_insn(32'hffff_0001, 3'd4);                      // c.nop, upper half ignored
    send_insn(32'h0000_8082, 3'd4);                      // c.ret
    send_insn(32'h0000_8282, 3'd4);                      // c.jr t0
    send_insn(32'h0000_9002, 3'd4);                      // c.ebreak
    send_insn(32'h0000_9282, 3'd4);                      // c.jalr t0
    send_insn(32'h0000_2001, 3'd4);                      // c.jal
    send_insn(32'h0000_1141, 3'd4);                      // c.addi sp, -16
    send_insn(32'h0000_017d, 3'd4);                      // c.addi sp, 31
    send_insn(32'h0000_7139, 3'd4);                      // c.addi16sp -64
    send_insn(32'h0000_6105, 3'd4);                      // c.addi16sp 32
    send_insn(32'h0000_bffd, 3'd2);                      // c.j -2
    send_insn(32'h0000_dffd, 3'd4);                      // c.beqz, negative
    send_insn(32'h0000_e001, 3'd4);                      // c.bnez 0
    send_insn(32'h0000_0001, 3'd1);                      // one byte left
    send_insn(enc_i(12'hff8, RegSp, F3Dword, RegRa, OpLoad), 3'd3);  // short full word
    send_insn(enc_i(12'hff8, RegSp, F3Dword, RegRa, OpLoad), 3'd7);  // saturated count
    send_insn(enc_s(12'h800, RegRa, RegSp, F3Dword), 3'd4);
    send_insn(enc_i(12'h800, RegSp, F3Zero, RegSp, OpImm), 3'd4);
    send_insn(enc_i(12'h010, RegSp, F3Zero, RegFp, OpImm), 3'd4);
    send_insn(enc_i(12'hff0, RegFp, F3Zero, RegSp, OpImm), 3'd4);    // frame restore
    send_insn(WordNop, 3'd4);
    send_insn({1'b1, 19'b0, RegZero, OpJal}, 3'd4);
    send_insn({1'b0, 10'h3ff, 1'b1, 8'hff, RegRa, OpJal}, 3'd4);
    send_insn(enc_i(12'h000, RegRa, F3Zero, RegZero, OpJalr), 3'd4);
    send_insn(enc_i(12'h000, 5'd5, F3Zero, RegRa, OpJalr), 3'd4);
    send_insn(enc_i(12'h004, RegRa, F3Zero, RegZero, OpJalr), 3'd4);
    send_insn(32'hffff_ffe3, 3'd4);                      // branch, odd funct3, all ones
    send_insn({1'b1, 6'b0, RegZero, RegZero, F3Zero, 4'b0, 1'b0, OpBranch}, 3'd4);
    send_insn(enc_i(F12Break, RegZero, F3Zero, RegZero, OpSystem), 3'd4);
    send_insn(enc_i(F12Sret, RegZero, F3Zero, RegZero, OpSystem), 3'd4);

    repeat (RandomItems) send_insn(rand_word(), pick_avail());

    in_tvalid <= 1'b0;
    // let the last input beat reach the monitor before reading its count
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Result side: mostly ready, short and long stalls, and one long hold-off that
  // backs the pipeline up into the input while beats keep coming.
  initial begin : receiver
    int r;
    int span;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (!long_hold_done && items_sent >= 400) begin
        rx_hold = 1'b1;
        long_hold_done = 1'b1;
        out_tready <= 1'b0;
        span = 150;
      end else if (r < 65) begin
        out_tready <= 1'b1;
        span = $urandom_range(1, 24);
      end else if (r < 95) begin
        out_tready <= 1'b0;
        span = $urandom_range(1, 3);
      end else begin
        out_tready <= 1'b0;
        span = $urandom_range(10, 40);
      end
      repeat (span) @(posedge clk);
      rx_hold = 1'b0;
    end
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

endmodule
